// ===== rtl/core/ose_pkg.sv =====
// Shared constants of the odometry speed estimator.
// Used by the channel interfaces, the top level, both checkers and the testbench; no dependencies.
`timescale 1ns / 1ps

package ose_pkg;

  // Field widths.
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned GAIN_W  = 17;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_VERTICAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FIRST     = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd13107;
  localparam logic [GAIN_W-1:0] Q16_ONE    = 17'd65536;

  // Source codes as shown on source_used.
  localparam logic SRC_VELOCITY = 1'b0;
  localparam logic SRC_POSE     = 1'b1;

  // Arithmetic sizes: sum of squares, root, scaled distance.
  localparam int unsigned ACC_W  = 68;
  localparam int unsigned ROOT_W = 34;
  localparam int unsigned SQR_W  = 36;
  localparam int unsigned NUM_W  = 54;
  localparam int unsigned CNT_W  = 6;

  localparam logic [STAMP_W-1:0] MIN_DT_US  = 48'd1;
  localparam logic [31:0]        US_PER_S   = 32'd1000000;
  localparam logic [ACC_W-1:0]   ROUND_HALF = 68'd32768;

endpackage

// ===== rtl/core/ose_in_if.sv =====
// Input channel of the odometry speed estimator: one odometry sample per transaction.
// Depends on ose_pkg for the field widths.
`timescale 1ns / 1ps

interface ose_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ose_pkg::VEL_W-1:0]    vel_x;
  logic signed [ose_pkg::VEL_W-1:0]    vel_y;
  logic signed [ose_pkg::VEL_W-1:0]    vel_z;
  logic                                vel_ok;
  logic signed [ose_pkg::POS_W-1:0]    pos_x;
  logic signed [ose_pkg::POS_W-1:0]    pos_y;
  logic signed [ose_pkg::POS_W-1:0]    pos_z;
  logic                                pos_ok;
  logic        [ose_pkg::STAMP_W-1:0]  stamp_us;

  modport source (
    output valid, vel_x, vel_y, vel_z, vel_ok, pos_x, pos_y, pos_z, pos_ok, stamp_us,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, vel_ok, pos_x, pos_y, pos_z, pos_ok, stamp_us,
    output ready
  );
endinterface

// ===== rtl/core/ose_out_if.sv =====
// Output channel of the odometry speed estimator: one speed estimate per transaction.
// Depends on ose_pkg for the field widths.
`timescale 1ns / 1ps

interface ose_out_if;
  logic                               valid;
  logic                               ready;
  logic [ose_pkg::SPEED_W-1:0]        speed;
  logic                               source_used;

  modport source (
    output valid, speed, source_used,
    input  ready
  );
  modport sink (
    input  valid, speed, source_used,
    output ready
  );
endinterface

// ===== rtl/core/odometry_speed_estimator.sv =====
// Top level of the odometry speed estimator: source selection, bit-serial arithmetic, filter.
// Depends on ose_pkg, ose_in_if and ose_out_if.
`timescale 1ns / 1ps

// How to use this block.
// Samples arrive on the sample channel and estimates leave on the estimate channel; a
// transaction happens on a rising edge where valid and ready are both high. The block
// works on one sample at a time: sample.ready is high only while the sequencer is idle.
// Each sample yields at most one estimate; when neither the velocity vector nor the pose
// difference gives a measurement, the sample is consumed silently.
// The work on a sample is done by the shared shift-and-add multiplier, which retires one
// multiplier bit per cycle, by the square root, which takes two radicand bits per cycle,
// and, for the pose source, by the restoring divider, which produces one quotient bit
// per cycle.
// The estimate sits in an output register. If the receiver stalls, the next sample is
// still accepted and processed; the sequencer only waits in its final step until the
// output register is free.
// Reset (synchronous, active high) returns the configuration registers to their defaults,
// forgets the stored pose and clears the filter state. Configuration is written through
// cfg_we, cfg_index and cfg_data while no sample is in flight; unknown indices are ignored.

module odometry_speed_estimator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ose_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ose_pkg::CFG_DATA_W-1:0]   cfg_data,
  ose_in_if.sink                           sample,
  ose_out_if.source                        estimate
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_SQ,
    S_ROOT,
    S_SCALE,
    S_DIV,
    S_FSET,
    S_FMUL,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic                             include_vertical;
  logic [ose_pkg::GAIN_W-1:0]       filter_gain;
  logic                             velocity_source_first;

  // Captured sample.
  logic [ose_pkg::VEL_W-1:0]        vel_x;
  logic [ose_pkg::VEL_W-1:0]        vel_y;
  logic [ose_pkg::VEL_W-1:0]        vel_z;
  logic                             vel_ok;
  logic [ose_pkg::POS_W-1:0]        pos_x;
  logic [ose_pkg::POS_W-1:0]        pos_y;
  logic [ose_pkg::POS_W-1:0]        pos_z;
  logic                             pos_ok;
  logic [ose_pkg::STAMP_W-1:0]      stamp;

  // Persistent state between samples.
  logic                             pose_seen;
  logic [ose_pkg::POS_W-1:0]        prev_x;
  logic [ose_pkg::POS_W-1:0]        prev_y;
  logic [ose_pkg::POS_W-1:0]        prev_z;
  logic [ose_pkg::STAMP_W-1:0]      prev_stamp;
  logic [ose_pkg::SPEED_W-1:0]      filtered_speed;

  // Sequencer and datapath registers.
  logic                             try_src;
  logic                             second_try;
  logic [1:0]                       term_idx;
  logic [ose_pkg::ACC_W-1:0]        acc;
  logic [ose_pkg::ACC_W-1:0]        mul_a;
  logic [31:0]                      mul_b;
  logic [ose_pkg::CNT_W-1:0]        cnt;
  logic [ose_pkg::ROOT_W-1:0]       root;
  logic [ose_pkg::SQR_W-1:0]        sq_rem;
  logic [ose_pkg::STAMP_W-1:0]      dt;
  logic [ose_pkg::STAMP_W-1:0]      div_rem;
  logic [31:0]                      quot;
  logic                             quot_ovf;
  logic [ose_pkg::SPEED_W-1:0]      meas;
  logic                             fphase;

  // Output register.
  logic                             out_valid;
  logic [ose_pkg::SPEED_W-1:0]      out_speed;
  logic                             out_src;

  // Combinational helpers.
  logic [1:0]                       term_sel;
  logic [1:0]                       last_term;
  logic [31:0]                      operand;
  logic [ose_pkg::STAMP_W-1:0]      stamp_diff;
  logic                             dt_ok;
  logic                             filter_on;
  logic [ose_pkg::SQR_W+1:0]        sq_shift;
  logic [ose_pkg::SQR_W+1:0]        sq_trial;
  logic                             sq_take;
  logic [ose_pkg::STAMP_W:0]        div_shift;
  logic                             div_take;
  logic [ose_pkg::SPEED_W-1:0]      filt_result;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] nd;
    d  = $signed({a[31], a}) - $signed({b[31], b});
    nd = -d;
    abs_diff = d[32] ? nd[31:0] : d[31:0];
  endfunction

  assign sample.ready         = (state == S_IDLE);
  assign estimate.valid       = out_valid;
  assign estimate.speed       = out_speed;
  assign estimate.source_used = out_src;

  assign last_term  = include_vertical ? 2'd2 : 2'd1;
  assign term_sel   = (state == S_PICK) ? 2'd0 : term_idx + 2'd1;
  assign stamp_diff = stamp - prev_stamp;
  // Time must move forward by more than the minimum step.
  assign dt_ok      = (stamp >= prev_stamp) && (stamp_diff > ose_pkg::MIN_DT_US);
  assign filter_on  = (filter_gain != '0) && !filter_gain[ose_pkg::GAIN_W-1];

  // Magnitude operand of the selected term, for either source.
  always_comb begin
    operand = '0;
    if (try_src == ose_pkg::SRC_VELOCITY) begin
      unique case (term_sel)
        2'd0:    operand = abs_diff(vel_x, 32'd0);
        2'd1:    operand = abs_diff(vel_y, 32'd0);
        2'd2:    operand = abs_diff(vel_z, 32'd0);
        default: operand = '0;
      endcase
    end else begin
      unique case (term_sel)
        2'd0:    operand = abs_diff(pos_x, prev_x);
        2'd1:    operand = abs_diff(pos_y, prev_y);
        2'd2:    operand = abs_diff(pos_z, prev_z);
        default: operand = '0;
      endcase
    end
  end

  // One step of the restoring square root: two radicand bits from the top of acc.
  assign sq_shift = {sq_rem, acc[ose_pkg::ACC_W-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_take  = (sq_shift >= sq_trial);

  // One step of the restoring divider: one numerator bit from acc.
  assign div_shift = {div_rem, acc[ose_pkg::NUM_W-1]};
  assign div_take  = (div_shift >= {1'b0, dt});

  assign filt_result = (acc[ose_pkg::ACC_W-1:48] != '0) ? '1 : acc[47:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      include_vertical      <= 1'b0;
      filter_gain           <= ose_pkg::GAIN_RESET;
      velocity_source_first <= 1'b1;
      pose_seen             <= 1'b0;
      filtered_speed        <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ose_pkg::CFG_INCLUDE_VERTICAL: include_vertical      <= cfg_data[0];
          ose_pkg::CFG_FILTER_GAIN:      filter_gain           <= cfg_data;
          ose_pkg::CFG_SOURCE_FIRST:     velocity_source_first <= cfg_data[0];
          default: ;
        endcase
      end

      // In the final step the output register is reloaded instead.
      if (out_valid && estimate.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            vel_x      <= sample.vel_x;
            vel_y      <= sample.vel_y;
            vel_z      <= sample.vel_z;
            vel_ok     <= sample.vel_ok;
            pos_x      <= sample.pos_x;
            pos_y      <= sample.pos_y;
            pos_z      <= sample.pos_z;
            pos_ok     <= sample.pos_ok;
            stamp      <= sample.stamp_us;
            try_src    <= velocity_source_first ? ose_pkg::SRC_VELOCITY : ose_pkg::SRC_POSE;
            second_try <= 1'b0;
            state      <= S_PICK;
          end
        end

        S_PICK: begin
          // Start the sum of squares for the current source, or fall back.
          if ((try_src == ose_pkg::SRC_VELOCITY && vel_ok) ||
              (try_src == ose_pkg::SRC_POSE && pos_ok && pose_seen && dt_ok)) begin
            dt       <= stamp_diff;
            term_idx <= 2'd0;
            acc      <= '0;
            mul_a    <= {{(ose_pkg::ACC_W-32){1'b0}}, operand};
            mul_b    <= operand;
            state    <= S_SQ;
          end else begin
            // The first valid pose is only remembered.
            if (try_src == ose_pkg::SRC_POSE && pos_ok && !pose_seen) begin
              prev_x     <= pos_x;
              prev_y     <= pos_y;
              prev_z     <= pos_z;
              prev_stamp <= stamp;
              pose_seen  <= 1'b1;
            end
            if (second_try) begin
              state <= S_IDLE;
            end else begin
              second_try <= 1'b1;
              try_src    <= ~try_src;
            end
          end
        end

        S_SQ: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (term_idx == last_term) begin
            root   <= '0;
            sq_rem <= '0;
            cnt    <= ose_pkg::CNT_W'(ose_pkg::ROOT_W - 1);
            state  <= S_ROOT;
          end else begin
            term_idx <= term_idx + 2'd1;
            mul_a    <= {{(ose_pkg::ACC_W-32){1'b0}}, operand};
            mul_b    <= operand;
          end
        end

        S_ROOT: begin
          if (sq_take) begin
            sq_rem <= ose_pkg::SQR_W'(sq_shift - sq_trial);
            root   <= {root[ose_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem <= ose_pkg::SQR_W'(sq_shift);
            root   <= {root[ose_pkg::ROOT_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt != '0) begin
            acc <= acc << 2;
          end else if (try_src == ose_pkg::SRC_VELOCITY) begin
            // The last root bit lands this cycle, so saturate on the shifted value.
            meas  <= (root[ose_pkg::ROOT_W-2:31] != '0) ? '1 :
                     {root[30:0], sq_take};
            state <= S_FSET;
          end else begin
            acc   <= '0;
            mul_a <= {{(ose_pkg::ACC_W-ose_pkg::ROOT_W){1'b0}},
                      root[ose_pkg::ROOT_W-2:0], sq_take};
            mul_b <= ose_pkg::US_PER_S;
            state <= S_SCALE;
          end
        end

        S_SCALE: begin
          // Distance times one million, ready for division by elapsed microseconds.
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            div_rem  <= '0;
            quot     <= '0;
            quot_ovf <= 1'b0;
            cnt      <= ose_pkg::CNT_W'(ose_pkg::NUM_W - 1);
            state    <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_take) begin
            div_rem <= ose_pkg::STAMP_W'(div_shift - {1'b0, dt});
          end else begin
            div_rem <= ose_pkg::STAMP_W'(div_shift);
          end
          quot     <= {quot[30:0], div_take};
          quot_ovf <= quot_ovf | quot[31];
          acc      <= acc << 1;
          cnt      <= cnt - 1'b1;
          if (cnt == '0) begin
            meas       <= (quot_ovf || quot[31]) ? '1 : {quot[30:0], div_take};
            prev_x     <= pos_x;
            prev_y     <= pos_y;
            prev_z     <= pos_z;
            prev_stamp <= stamp;
            state      <= S_FSET;
          end
        end

        S_FSET: begin
          if (filter_on) begin
            acc    <= ose_pkg::ROUND_HALF;
            mul_a  <= {{(ose_pkg::ACC_W-ose_pkg::SPEED_W){1'b0}}, meas};
            mul_b  <= {16'd0, filter_gain[15:0]};
            fphase <= 1'b0;
            state  <= S_FMUL;
          end else begin
            state <= S_OUT;
          end
        end

        S_FMUL: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (!fphase) begin
            mul_a  <= {{(ose_pkg::ACC_W-ose_pkg::SPEED_W){1'b0}}, filtered_speed};
            mul_b  <= {15'd0, ose_pkg::GAIN_W'(ose_pkg::Q16_ONE - filter_gain)};
            fphase <= 1'b1;
          end else begin
            meas  <= filt_result;
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid || estimate.ready) begin
            out_valid      <= 1'b1;
            out_speed      <= meas;
            out_src        <= try_src;
            filtered_speed <= meas;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ose_checker.sv =====
// Port-level checks of the odometry speed estimator, bound to the top level.
// Depends on ose_pkg and odometry_speed_estimator.
`timescale 1ns / 1ps

module ose_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ose_pkg::SPEED_W-1:0]   speed,
  input logic                          source_used
);

  // The block holds one sample at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while another was in flight");

  // An estimate cannot appear in the cycle straight after a transaction on the input.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("estimate appeared too early");

  // A new estimate is only loaded while the sequencer is busy.
  a_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("estimate loaded while idle");

  // A stalled estimate stays on offer with its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed) && $stable(source_used))
    else $error("stalled estimate dropped or changed");

endmodule

bind odometry_speed_estimator ose_checker u_ose_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (estimate.valid),
  .out_ready   (estimate.ready),
  .speed       (estimate.speed),
  .source_used (estimate.source_used)
);

// ===== sim/ose_speed_checker.sv =====
// Checker for the odometry speed estimator: follows configuration writes and accepted samples,
// predicts each speed estimate and compares it with the estimate channel.
// Depends on ose_pkg, ose_in_if and ose_out_if.
`timescale 1ns / 1ps

module ose_speed_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ose_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ose_pkg::CFG_DATA_W-1:0] cfg_data,
  ose_in_if                              sample,
  ose_out_if                             estimate,
  output int                             errors,
  output int                             pending
);
  import ose_pkg::*;

  typedef struct {
    logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
    logic                    vel_ok;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic                    pos_ok;
    logic [STAMP_W-1:0]      stamp_us;
  } odo_t;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic               source_used;
  } speed_est_t;

  speed_est_t estimates_due[$];

  // Shadow of the configuration registers and of the block's state.
  logic                    vertical_on;
  logic [GAIN_W-1:0]       gain;
  logic                    velocity_first;
  logic                    pose_known;
  logic signed [POS_W-1:0] last_x, last_y, last_z;
  logic [STAMP_W-1:0]      last_stamp;
  logic [SPEED_W-1:0]      smoothed;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [SPEED_W-1:0] got,
                                 input logic [SPEED_W-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [ACC_W-1:0] square_abs(input logic signed [32:0] d);
    logic [ACC_W-1:0] m;
    m = (d < 0) ? ACC_W'(-d) : ACC_W'(d);
    return m * m;
  endfunction

  // Digit-by-digit root, two radicand bits per step, truncated.
  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [ACC_W-1:0] v);
    logic [ACC_W+1:0] rem, trial;
    logic [ROOT_W-1:0] root;
    rem  = '0;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      rem   = (rem << 2) | (ACC_W+2)'(v[2*i +: 2]);
      trial = ((ACC_W+2)'(root) << 2) | (ACC_W+2)'(1);
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[ROOT_W-2:0], 1'b1};
      end else begin
        root = {root[ROOT_W-2:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_u32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[SPEED_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] vector_speed(input odo_t s);
    logic [ACC_W-1:0] sum;
    sum = square_abs(33'(s.vel_x)) + square_abs(33'(s.vel_y));
    if (vertical_on) begin
      sum = sum + square_abs(33'(s.vel_z));
    end
    return clamp_u32(64'(floor_sqrt(sum)));
  endfunction

  // Speed from the pose difference; updates the stored pose as the block does.
  function automatic bit pose_speed(input odo_t s, output logic [SPEED_W-1:0] meas);
    logic [ACC_W-1:0] sum;
    logic [63:0] dt, span;
    meas = '0;
    if (!s.pos_ok) return 1'b0;
    if (!pose_known) begin
      last_x     = s.pos_x;
      last_y     = s.pos_y;
      last_z     = s.pos_z;
      last_stamp = s.stamp_us;
      pose_known = 1'b1;
      return 1'b0;
    end
    if (s.stamp_us < last_stamp) return 1'b0;
    dt = 64'(s.stamp_us - last_stamp);
    if (dt <= 64'(MIN_DT_US)) return 1'b0;
    sum = square_abs(33'(s.pos_x) - 33'(last_x)) + square_abs(33'(s.pos_y) - 33'(last_y));
    if (vertical_on) begin
      sum = sum + square_abs(33'(s.pos_z) - 33'(last_z));
    end
    span = 64'(floor_sqrt(sum));
    meas = clamp_u32(span * 64'(US_PER_S) / dt);
    last_x     = s.pos_x;
    last_y     = s.pos_y;
    last_z     = s.pos_z;
    last_stamp = s.stamp_us;
    return 1'b1;
  endfunction

  function automatic bit compute_estimate(input odo_t s, output speed_est_t est);
    logic [SPEED_W-1:0] meas;
    logic [63:0] mix;
    bit have;
    est.speed = '0;
    meas      = '0;
    if (velocity_first) begin
      est.source_used = SRC_VELOCITY;
      have = s.vel_ok;
      if (have) begin
        meas = vector_speed(s);
      end else begin
        est.source_used = SRC_POSE;
        have = pose_speed(s, meas);
      end
    end else begin
      est.source_used = SRC_POSE;
      have = pose_speed(s, meas);
      if (!have) begin
        est.source_used = SRC_VELOCITY;
        have = s.vel_ok;
        if (have) begin
          meas = vector_speed(s);
        end
      end
    end
    if (!have) return 1'b0;
    if (gain != '0 && gain < Q16_ONE) begin
      mix = 64'(gain) * 64'(meas) + (64'(Q16_ONE) - 64'(gain)) * 64'(smoothed)
          + 64'(ROUND_HALF);
      est.speed = clamp_u32(mix >> 16);
    end else begin
      est.speed = meas;
    end
    smoothed = est.speed;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    odo_t       s;
    speed_est_t est, due;
    if (rst) begin
      vertical_on    = 1'b0;
      gain           = GAIN_RESET;
      velocity_first = 1'b1;
      pose_known     = 1'b0;
      last_x         = '0;
      last_y         = '0;
      last_z         = '0;
      last_stamp     = '0;
      smoothed       = '0;
      estimates_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INCLUDE_VERTICAL: vertical_on = cfg_data[0];
          CFG_FILTER_GAIN:      gain = cfg_data[GAIN_W-1:0];
          CFG_SOURCE_FIRST:     velocity_first = cfg_data[0];
          default: ;
        endcase
      end
      // Retire the oldest estimate before predicting from a sample taken at the same edge.
      if (estimate.valid && estimate.ready) begin
        if (estimates_due.size() == 0) begin
          report_mismatch("estimate with no sample behind it, speed", estimate.speed, '0);
        end else begin
          due = estimates_due.pop_front();
          if (estimate.speed !== due.speed) begin
            report_mismatch("speed", estimate.speed, due.speed);
          end
          if (estimate.source_used !== due.source_used) begin
            report_mismatch("source_used", SPEED_W'(estimate.source_used),
                            SPEED_W'(due.source_used));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        s.vel_x    = sample.vel_x;
        s.vel_y    = sample.vel_y;
        s.vel_z    = sample.vel_z;
        s.vel_ok   = sample.vel_ok;
        s.pos_x    = sample.pos_x;
        s.pos_y    = sample.pos_y;
        s.pos_z    = sample.pos_z;
        s.pos_ok   = sample.pos_ok;
        s.stamp_us = sample.stamp_us;
        if (compute_estimate(s, est)) begin
          estimates_due.push_back(est);
        end
      end
    end
    pending = estimates_due.size();
  end

endmodule

// ===== sim/odometry_speed_estimator_tb.sv =====
// Top of the odometry speed estimator testbench: clock, reset, configuration, sample stimulus,
// estimate back-pressure, idle watchdog and verdict. Depends on ose_pkg, the two channel
// interfaces, the block itself and ose_speed_checker.
`timescale 1ns / 1ps

module odometry_speed_estimator_tb;
  import ose_pkg::*;

  // The idle limit covers the block's work on one sample plus the longest time that an
  // estimate may wait on the receiver, so a longer run without any transaction means the
  // block has hung.
  localparam int unsigned IDLE_LIMIT      = 4000;
  // Cycles allowed after the last expected estimate, in case the block is still chewing
  // on a sample that will produce nothing.
  localparam int unsigned DRAIN_CYCLES    = 320;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 88;
  // An index that names no register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
    logic                    vel_ok;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic                    pos_ok;
    logic [STAMP_W-1:0]      stamp_us;
  } odo_sample_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    errors;
  int                    pending;
  // When set, neither side inserts idle cycles, so each side offers its next transaction at once.
  bit                    calm = 1'b0;
  int unsigned           idle_cycles = 0;

  // Running trajectory from which well-formed samples are drawn.
  logic [STAMP_W-1:0]      trk_stamp;
  logic signed [POS_W-1:0] trk_x, trk_y, trk_z;

  ose_in_if  sample_ch();
  ose_out_if estimate_ch();

  odometry_speed_estimator dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .sample   (sample_ch),
    .estimate (estimate_ch)
  );

  ose_speed_checker speed_chk (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .sample   (sample_ch),
    .estimate (estimate_ch),
    .errors,
    .pending
  );

  always #1 clk = ~clk;

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (estimate_ch.valid && estimate_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Estimate receiver. Before each transaction it holds ready low for a random number of
  // cycles, then keeps it high until an estimate has been taken.
  initial begin
    int unsigned stall;
    estimate_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        estimate_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      estimate_ch.ready <= 1'b1;
      @(posedge clk);
      while (!estimate_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic odo_sample_t odo(input logic [31:0] vx, vy, vz, input logic vok,
                                      input logic [31:0] px, py, pz, input logic pok,
                                      input logic [STAMP_W-1:0] stamp);
    odo_sample_t s;
    s.vel_x    = vx;
    s.vel_y    = vy;
    s.vel_z    = vz;
    s.vel_ok   = vok;
    s.pos_x    = px;
    s.pos_y    = py;
    s.pos_z    = pz;
    s.pos_ok   = pok;
    s.stamp_us = stamp;
    return s;
  endfunction

  // Mostly a moderate speed of up to about 64 m/s per axis, now and then any 32-bit value.
  function automatic logic [31:0] velocity_part();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($urandom_range(0, 8388608)) - 32'd4194304;
  endfunction

  // Three samples in four follow the trajectory: the stamp advances by a realistic step
  // (occasionally by two microseconds or less) and the position moves by up to 16 m per
  // axis. The rest is noise with every field random; noise that carries a valid position
  // keeps its stamp close to the trajectory so that time may also step back, without
  // cutting off the pose path for the rest of the run.
  function automatic odo_sample_t random_sample();
    odo_sample_t s;
    if ($urandom_range(0, 3) == 0) begin
      s = odo($urandom, $urandom, $urandom, 1'($urandom), $urandom, $urandom, $urandom,
              1'($urandom), {16'($urandom), 32'($urandom)});
      if (s.pos_ok) begin
        s.stamp_us = trk_stamp + STAMP_W'($urandom_range(0, 6)) - STAMP_W'(3);
      end
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        trk_stamp = trk_stamp + STAMP_W'($urandom_range(0, 2));
      end else begin
        trk_stamp = trk_stamp + STAMP_W'($urandom_range(2, 50000));
      end
      trk_x = trk_x + POS_W'($urandom_range(0, 2097152)) - POS_W'(1048576);
      trk_y = trk_y + POS_W'($urandom_range(0, 2097152)) - POS_W'(1048576);
      trk_z = trk_z + POS_W'($urandom_range(0, 2097152)) - POS_W'(1048576);
      s = odo(velocity_part(), velocity_part(), velocity_part(), $urandom_range(0, 9) < 7,
              trk_x, trk_y, trk_z, $urandom_range(0, 9) < 9, trk_stamp);
    end
    return s;
  endfunction

  // Offer one sample after a random gap and return at the falling edge after its
  // transaction. With no gap, valid simply stays high for the next sample.
  task automatic send_sample(input odo_sample_t s);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.vel_x    <= s.vel_x;
    sample_ch.vel_y    <= s.vel_y;
    sample_ch.vel_z    <= s.vel_z;
    sample_ch.vel_ok   <= s.vel_ok;
    sample_ch.pos_x    <= s.pos_x;
    sample_ch.pos_y    <= s.pos_y;
    sample_ch.pos_z    <= s.pos_z;
    sample_ch.pos_ok   <= s.pos_ok;
    sample_ch.stamp_us <= s.stamp_us;
    sample_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // The one-bit registers get random upper data bits, which the block must ignore.
  task automatic configure(input logic incl, input logic [GAIN_W-1:0] g, input logic vfirst);
    write_reg(CFG_INCLUDE_VERTICAL, {16'($urandom), incl});
    write_reg(CFG_FILTER_GAIN, CFG_DATA_W'(g));
    write_reg(CFG_SOURCE_FIRST, {16'($urandom), vfirst});
  endtask

  // Hold the sender back until every predicted estimate has been taken, then let the block
  // finish any sample that produces nothing. Configuration is only written after this.
  task automatic wait_quiet();
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [GAIN_W-1:0] phase_gain [PHASES];
    logic [GAIN_W-1:0] g;
    phase_gain = '{17'd1, 17'd65535, 17'd65536, 17'd131071, 17'd13107, 17'd0, 17'd0, 17'd0};
    sample_ch.valid    = 1'b0;
    sample_ch.vel_x    = '0;
    sample_ch.vel_y    = '0;
    sample_ch.vel_z    = '0;
    sample_ch.vel_ok   = 1'b0;
    sample_ch.pos_x    = '0;
    sample_ch.pos_y    = '0;
    sample_ch.pos_z    = '0;
    sample_ch.pos_ok   = 1'b0;
    sample_ch.stamp_us = '0;
    // The random trajectory starts above every stamp that the directed part stores.
    trk_stamp = 48'h8000_0000_0000 + STAMP_W'($urandom);
    trk_x     = '0;
    trk_y     = '0;
    trk_z     = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // A write to an index with no register behind it must change nothing.
    write_reg(CFG_UNUSED, '1);

    // Directed part under the reset configuration: planar magnitude, filter on, velocity
    // tried first. Extreme velocity components, zero speed, nothing valid at all.
    send_sample(odo(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '0, '0, '0, 1'b0,
                    48'd0));
    send_sample(odo(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b1, '0, '0, '0, 1'b0, 48'd10));
    send_sample(odo('0, '0, '0, 1'b1, '0, '0, '0, 1'b0, 48'd20));
    send_sample(odo(32'h0001_0000, '0, '0, 1'b0, '0, '0, '0, 1'b0, 48'd30));
    // Pose fallback: the first pose is only stored; then a repeated stamp, a step of
    // exactly the minimum interval and a stamp going backwards all give nothing.
    send_sample(odo('0, '0, '0, 1'b0, 32'h0010_0000, 32'hFFF0_0000, '0, 1'b1, 48'd1000));
    send_sample(odo('0, '0, '0, 1'b0, 32'h0020_0000, 32'hFFF0_0000, '0, 1'b1, 48'd1000));
    send_sample(odo('0, '0, '0, 1'b0, 32'h0020_0000, 32'hFFF0_0000, '0, 1'b1, 48'd1001));
    send_sample(odo('0, '0, '0, 1'b0, 32'h0020_0000, 32'hFFF0_0000, '0, 1'b1, 48'd999));
    // One metre in two microseconds saturates; then 5 m in one second.
    send_sample(odo('0, '0, '0, 1'b0, 32'h0011_0000, 32'hFFF0_0000, '0, 1'b1, 48'd1002));
    send_sample(odo('0, '0, '0, 1'b0, 32'h0014_0000, 32'hFFF4_0000, '0, 1'b1,
                    48'd1001002));
    // Valid velocity wins, so the stored pose must stay untouched.
    send_sample(odo(32'h0003_0000, 32'h0004_0000, '0, 1'b1, '0, '0, '0, 1'b1, 48'd2000000));
    send_sample(odo('0, '0, '0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                    48'd2001002));
    wait_quiet();

    // Spatial magnitude, no filtering, pose difference tried first.
    configure(1'b1, '0, 1'b0);
    send_sample(odo(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, '0, '0, '0, 1'b0,
                    48'd3000000));
    // The largest possible distance, on all three axes.
    send_sample(odo(32'h0001_0000, '0, '0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    1'b1, 48'd3001002));
    // Time has not advanced enough, so the velocity vector stands in.
    send_sample(odo(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1, '0, '0, '0, 1'b1,
                    48'd3001003));
    send_sample(odo('0, '0, '0, 1'b0, '0, '0, '0, 1'b1, 48'h8000_0000_0000));
    send_sample(odo(32'h0001_0000, '0, '0, 1'b0, '0, '0, '0, 1'b0, 48'd4000000));
    send_sample(odo(32'h0000_0001, 32'hFFFF_FFFF, '0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0, 48'hFFFF_FFFF_FFFF));

    // Random part. Each phase waits for the block to drain, then rewrites all three
    // registers; the phases walk through every source and dimension choice and through
    // the gain extremes, and two of them run without idle cycles on either side.
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      calm = (p == 2 || p == 5);
      g = (p == 5 || p == 6) ? GAIN_W'($urandom_range(1, 65535)) : phase_gain[p];
      configure(1'(p), g, 1'(p >> 1));
      repeat (ITEMS_PER_PHASE) send_sample(random_sample());
    end

    wait_quiet();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ose_pkg.sv
rtl/core/ose_in_if.sv
rtl/core/ose_out_if.sv
rtl/core/odometry_speed_estimator.sv
rtl/core/ose_checker.sv
sim/ose_speed_checker.sv
sim/odometry_speed_estimator_tb.sv
